/* hdl/url_percent_decoder_macros.svh */
// Assertion macros shared by the checker of the URL percent decoder.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("url_percent_decoder: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("url_percent_decoder: assertion failed");

`endif

/* hdl/updec_pkg.sv */
// Types, character constants and helper functions of the URL percent decoder.
// No dependencies; imported by the front end, queue, back end, top level, scoreboard and testbench.
package updec_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [3:0] NIB_ALPHA_OFS = 4'd10;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef enum logic {
        OP_ONE = 1'b0,
        OP_TWO = 1'b1
    } t_op_kind;

    // One queued operation: OP_TWO emits a literal '%' before the data byte.
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic       last;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            diff = ch - CH_ZERO;
            return diff[3:0];
        end
        if (ch >= CH_UA && ch <= CH_UF) begin
            diff = ch - CH_UA;
            return diff[3:0] + NIB_ALPHA_OFS;
        end
        if (ch >= CH_LA && ch <= CH_LF) begin
            diff = ch - CH_LA;
            return diff[3:0] + NIB_ALPHA_OFS;
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] ch);
        return (ch == CH_PLUS) ? CH_SPACE : ch;
    endfunction

endpackage

/* hdl/updec_if.sv */
// Valid/ready stream interfaces for the encoded input and the decoded output.
// No dependencies.
interface updec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface updec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* hdl/updec_front.sv */
// Front end: accepts encoded beats, tracks the escape phase, classifies each beat.
// Depends on updec_pkg and updec_in_if.
module updec_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    updec_in_if.sink              i_in,
    input  updec_pkg::t_q_status  i_q_status,
    output logic                  o_push,
    output updec_pkg::t_op        o_op
);
    import updec_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_high;
    logic [3:0] n_high;
    logic       accept;
    logic       has_result;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && !i_q_status.full;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_PCT:   n_phase = i_in.in_last ? PH_IDLE : PH_DIGIT;
                PH_DIGIT: n_phase = PH_IDLE;
                default:  n_phase = (i_in.in_byte == CH_PCT && !i_in.in_last) ? PH_PCT : PH_IDLE;
            endcase
        end
    end

    always_comb begin
        has_result = 1'b1;
        n_high     = r_high;
        o_op.kind  = OP_ONE;
        o_op.data  = plain_byte(i_in.in_byte);
        o_op.last  = i_in.in_last;
        case (r_phase)
            PH_PCT: begin
                // A string cut short after '%' gives the '%' back, then the byte.
                has_result = i_in.in_last;
                o_op.kind  = OP_TWO;
                if (!i_in.in_last && accept) begin
                    n_high = nibble_of(i_in.in_byte);
                end
            end
            PH_DIGIT: begin
                o_op.data = {r_high, nibble_of(i_in.in_byte)};
            end
            default: begin
                has_result = !(i_in.in_byte == CH_PCT && !i_in.in_last);
            end
        endcase
        o_push = accept && has_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

endmodule

/* hdl/updec_queue.sv */
// Short operation queue between the front end and the back end.
// Depends on updec_pkg.
module updec_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  updec_pkg::t_op       i_op,
    input  logic                 i_pop,
    output updec_pkg::t_op       o_op,
    output updec_pkg::t_q_status o_status
);
    import updec_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_op           = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/updec_back.sv */
// Back end: carries out queued operations into a registered output stage.
// Depends on updec_pkg and updec_out_if.
module updec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  updec_pkg::t_q_status  i_q_status,
    input  updec_pkg::t_op        i_op,
    output logic                  o_pop,
    updec_out_if.source           o_out
);
    import updec_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pend;
    logic [7:0] r_pend_byte;
    logic       r_pend_last;
    logic       load;

    assign load           = !r_valid || o_out.ready;
    assign o_pop          = load && !r_pend && !i_q_status.empty;
    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_byte  <= r_pend_byte;
                r_last  <= r_pend_last;
                r_pend  <= 1'b0;
            end else if (!i_q_status.empty) begin
                r_valid <= 1'b1;
                if (i_op.kind == OP_TWO) begin
                    r_byte      <= CH_PCT;
                    r_last      <= 1'b0;
                    r_pend      <= 1'b1;
                    r_pend_byte <= i_op.data;
                    r_pend_last <= i_op.last;
                end else begin
                    r_byte <= i_op.data;
                    r_last <= i_op.last;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/url_percent_decoder.sv */
// URL percent decoder top level: front end, operation queue, back end.
// Depends on updec_pkg, updec_if and the three updec_ submodules.
// Sync active-low reset. An accepted beat is queued, then loaded into the
// output register. One input beat per cycle unless the queue is full; a beat
// that restores a cut-off '%' gives two output beats, which the queue absorbs.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    updec_in_if.sink    i_in,
    updec_out_if.source o_out
);
    import updec_pkg::*;

    // The front end decides per beat whether a result is owed and what it is:
    // a plain byte ('+' turned to space), a decoded escape, or a '%' followed
    // by a plain byte when the string ends right after a '%'. It pushes that
    // decision into the queue, so the back end never needs the escape phase.
    t_q_status q_status;
    t_op       push_op;
    t_op       pop_op;
    logic      push;
    logic      pop;

    updec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_op       (push_op)
    );

    // The queue lets the input keep flowing while the output is stalled or
    // while a two-beat result is being emitted.
    updec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_op     (pop_op),
        .o_status (q_status)
    );

    // The back end owns the output register, so a waiting result never
    // blocks the next pop unless the sink stalls or a second beat is pending.
    updec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_op       (pop_op),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

/* hdl/updec_checker.sv */
// Port-level checker for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_macros.svh.
`include "url_percent_decoder_macros.svh"

module updec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    logic       in_last_beat;
    logic       out_last_beat;
    logic       out_stall;
    logic [8:0] out_payload;
    logic [7:0] r_open;

    assign in_last_beat  = i_in_valid && i_in_ready && i_in_last;
    assign out_last_beat = i_out_valid && i_out_ready && i_out_last;
    assign out_stall     = i_out_valid && !i_out_ready;
    assign out_payload   = {i_out_byte, i_out_last};

    // Strings whose final input beat is in but whose final output beat is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 8'd0;
        end else begin
            case ({in_last_beat, out_last_beat})
                2'b10:   r_open <= r_open + 1'b1;
                2'b01:   r_open <= r_open - 1'b1;
                default: r_open <= r_open;
            endcase
        end
    end

    `UPD_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(out_payload))
    `UPD_ASSERT_IMPL(a_last_owed, out_last_beat, r_open != 8'd0)
    `UPD_ASSERT_IMPL(a_reset_quiet, $past(i_rst_n) == 1'b0, !i_out_valid)
    `UPD_ASSERT_IMPL(a_no_last_early, r_open == 8'd0, !(i_out_valid && i_out_last))

endmodule

bind url_percent_decoder updec_checker u_updec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.in_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

/* sim/updec_scoreboard_pkg.sv */
// Scoreboard for the URL percent decoder testbench: its own decoder model and checks.
// Depends on updec_pkg for the phase enum and the character constants.
package updec_scoreboard_pkg;
    import updec_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    class decode_scoreboard;
        t_phase      phase;
        logic [3:0]  saved_high;
        t_decoded    pending_decoded[$];
        int unsigned encoded_beats;
        int unsigned decoded_beats;
        int unsigned split_escapes;
        int unsigned mismatches;

        function new();
            phase         = PH_IDLE;
            saved_high    = 4'd0;
            encoded_beats = 0;
            decoded_beats = 0;
            split_escapes = 0;
            mismatches    = 0;
        endfunction

        // Anything that is not a hex digit counts as zero.
        function logic [3:0] hex_digit_value(input logic [7:0] ch);
            logic [7:0] ofs;
            ofs = 8'd0;
            if (ch >= "0" && ch <= "9") begin
                ofs = ch - 8'h30;
            end else if (ch >= "A" && ch <= "F") begin
                ofs = ch - 8'h37;
            end else if (ch >= "a" && ch <= "f") begin
                ofs = ch - 8'h57;
            end
            return ofs[3:0];
        endfunction

        function logic [7:0] unplus(input logic [7:0] ch);
            return (ch == CH_PLUS) ? CH_SPACE : ch;
        endfunction

        function void push_decoded(input logic [7:0] data, input logic last);
            t_decoded d;
            d.data = data;
            d.last = last;
            pending_decoded = {pending_decoded, d};
        endfunction

        // Advances the model by one accepted encoded beat.
        function void absorb_encoded(input logic [7:0] ch, input logic last);
            encoded_beats++;
            case (phase)
                PH_PCT: begin
                    if (last) begin
                        // The string was cut right after the percent sign.
                        push_decoded(CH_PCT, 1'b0);
                        push_decoded(unplus(ch), 1'b1);
                        split_escapes++;
                        phase = PH_IDLE;
                    end else begin
                        saved_high = hex_digit_value(ch);
                        phase      = PH_DIGIT;
                    end
                end
                PH_DIGIT: begin
                    push_decoded({saved_high, hex_digit_value(ch)}, last);
                    phase = PH_IDLE;
                end
                default: begin
                    phase = PH_IDLE;
                    if (ch == CH_PCT && !last) begin
                        phase = PH_PCT;
                    end else begin
                        push_decoded(unplus(ch), last);
                    end
                end
            endcase
        endfunction

        function void check_decoded(input logic [7:0] data, input logic last);
            t_decoded exp_beat;
            decoded_beats++;
            if (pending_decoded.size() == 0) begin
                $error("unexpected decoded beat: out_byte 0x%02h out_last %0b", data, last);
                mismatches++;
                return;
            end
            exp_beat = pending_decoded.pop_front();
            if (data !== exp_beat.data) begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", exp_beat.data, data);
                mismatches++;
            end
            if (last !== exp_beat.last) begin
                $error("out_last: expected %0b, actual %0b", exp_beat.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_decoded.size();
        endfunction
    endclass

endpackage

/* sim/url_percent_decoder_tb.sv */
// Self-checking testbench for url_percent_decoder: directed strings, then random ones.
// Depends on updec_pkg, updec_if, the decoder RTL and updec_scoreboard_pkg.
module url_percent_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import updec_pkg::*;
    import updec_scoreboard_pkg::*;

    // Generous ceiling on the whole run; a healthy run needs a small part of it.
    localparam time RUN_LIMIT = 4ms;
    // Encoded beats per random phase; four phases give at least 1960 in total.
    localparam int PHASE_BEATS = 490;
    // Extra cycles to wait after the last expected beat.
    localparam int SETTLE_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    updec_in_if  enc_bus ();
    updec_out_if dec_bus ();

    url_percent_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (enc_bus),
        .o_out   (dec_bus)
    );

    decode_scoreboard board;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned strings_sent;

    string hex_chars = "0123456789abcdefABCDEF";

    always #4 i_clk = ~i_clk;

    // The receiver checks every decoded beat it accepts, then picks its ready for
    // the next cycle. Values read here are the ones present at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && dec_bus.valid && dec_bus.ready) begin
            board.check_decoded(dec_bus.out_byte, dec_bus.out_last);
        end
        dec_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one encoded beat, with random hold-off cycles before it, and returns
    // at the edge where the beat is accepted. Valid is left high, so the next call
    // either replaces the payload or lowers valid in a later time step.
    task automatic send_beat(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            enc_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        enc_bus.valid   <= 1'b1;
        enc_bus.in_byte <= ch;
        enc_bus.in_last <= last;
        do @(posedge i_clk); while (!enc_bus.ready);
        board.absorb_encoded(ch, last);
    endtask

    task automatic send_string(input logic [7:0] text[$]);
        foreach (text[i]) begin
            send_beat(text[i], i == text.size() - 1);
        end
        strings_sent++;
    endtask

    // The sender stays quiet until every decoded beat it caused has come out.
    task automatic drain();
        enc_bus.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Covers the byte extremes, the plus sign, upper and lower case digits, a
    // non-hex digit, and each way a string can end inside an escape.
    task automatic run_directed();
        send_string('{8'h00});
        send_string('{8'hFF});
        send_string('{CH_PLUS});
        send_string('{CH_PCT, "4", "1"});
        send_string('{CH_PCT, "f", "F", CH_PCT, "z", "!", "a"});
        send_string('{CH_PCT});
        send_string('{CH_PCT, CH_PLUS});
        send_string('{CH_PCT, CH_PCT});
        send_string('{"x", CH_PCT, "C"});
    endtask

    // Builds strings that are mostly well-formed escapes and plain text, with some
    // raw bytes and stray percent signs so that strings also end mid-escape.
    task automatic run_random(input int unsigned beats);
        logic [7:0]  text[$];
        int unsigned pieces;
        int unsigned pick;
        int unsigned sent;
        sent = 0;
        while (sent < beats) begin
            text.delete();
            pieces = $urandom_range(1, 8);
            repeat (pieces) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    text = {text, CH_PCT};
                    text = {text, hex_chars[$urandom_range(21)]};
                    text = {text, hex_chars[$urandom_range(21)]};
                end else if (pick < 55) begin
                    text = {text, CH_PLUS};
                end else if (pick < 78) begin
                    text = {text, 8'($urandom_range(8'h20, 8'h7E))};
                end else if (pick < 90) begin
                    text = {text, 8'($urandom_range(255))};
                end else if (pick < 95) begin
                    // Broken escape: a percent sign with at most one digit.
                    text = {text, CH_PCT};
                    if ($urandom_range(1)) begin
                        text = {text, hex_chars[$urandom_range(21)]};
                    end
                end else begin
                    // Escape whose digits may be any byte at all.
                    text = {text, CH_PCT};
                    text = {text, 8'($urandom_range(255))};
                    text = {text, 8'($urandom_range(255))};
                end
            end
            send_string(text);
            sent += text.size();
        end
    endtask

    initial begin
        board           = new();
        strings_sent    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         <= 1'b0;
        enc_bus.valid   <= 1'b0;
        enc_bus.in_byte <= 8'h00;
        enc_bus.in_last <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();

        // Phase one runs flat out on both sides.
        run_random(PHASE_BEATS);
        drain();

        send_idle_pct  = 47;
        recv_stall_pct = 0;
        run_random(PHASE_BEATS);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 47;
        run_random(PHASE_BEATS);
        drain();

        send_idle_pct  = 18;
        recv_stall_pct = 18;
        run_random(PHASE_BEATS);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.outstanding() != 0) begin
            $error("%0d expected decoded beats never arrived", board.outstanding());
            board.mismatches++;
        end

        $display("Run covered %0d encoded beats in %0d strings, %0d decoded beats checked,",
                 board.encoded_beats, strings_sent, board.decoded_beats);
        $display("  %0d strings cut after a percent sign, over four stall patterns.",
                 board.split_escapes);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
